// ----- rtl/b3h_pkg.sv -----
// Shared types, constants and state codes of the BLAKE3 stream hasher.
package b3h_pkg;

    typedef logic [7:0][31:0]  t_cv;
    typedef logic [15:0][31:0] t_blk;

    localparam t_cv IV = {
        32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
        32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667
    };

    localparam logic [15:0][3:0] PERM = {
        4'd8, 4'd15, 4'd14, 4'd9, 4'd5, 4'd12, 4'd11, 4'd1,
        4'd13, 4'd4, 4'd0, 4'd7, 4'd10, 4'd3, 4'd6, 4'd2
    };

    localparam logic [3:0] FLAG_CHUNK_START = 4'd1;
    localparam logic [3:0] FLAG_CHUNK_END   = 4'd2;
    localparam logic [3:0] FLAG_PARENT      = 4'd4;
    localparam logic [3:0] FLAG_ROOT        = 4'd8;

    localparam logic [6:0] BLOCK_BYTES = 7'd64;
    localparam logic [3:0] LAST_BLOCK  = 4'd15;
    localparam logic [6:0] MAX_WORDS   = 7'd64;
    localparam logic [6:0] OW_RESET    = 7'd8;
    localparam logic [4:0] LOAD_WORDS  = 5'd16;

    typedef struct packed {
        logic        start;
        logic        ld_en;
        logic [31:0] ld_word;
        logic [6:0]  len;
        logic [63:0] ctr;
        logic [3:0]  flags;
        t_cv         cv;
    } t_cmp_req;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_GO, S_COMP, S_MERGE, S_BYTE, S_FOLD, S_ROOT, S_EMIT, S_WAIT
    } t_state;

    typedef enum logic [2:0] {
        J_BLOCK, J_CHUNK, J_MERGE, J_FCHUNK, J_FOLD, J_ROOT
    } t_job;

    typedef enum logic {
        SRC_BUF, SRC_PAIR
    } t_src;

endpackage

// ----- rtl/b3h_in_if.sv -----
// Input channel: message byte or finish request.
interface b3h_in_if;
    logic       valid;
    logic       ready;
    logic [0:0] kind;
    logic [7:0] data_byte;

    modport source (output valid, kind, data_byte, input ready);
    modport sink (input valid, kind, data_byte, output ready);
endinterface

// ----- rtl/b3h_out_if.sv -----
// Output channel: digest words.
interface b3h_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] hash_word;
    logic [5:0]  word_index;
    logic [0:0]  last;

    modport source (output valid, hash_word, word_index, last, input ready);
    modport sink (input valid, hash_word, word_index, last, output ready);
endinterface

// ----- rtl/b3h_cfg_if.sv -----
// Configuration write channel: digest word count.
interface b3h_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] out_words;

    modport source (output valid, out_words, input ready);
    modport sink (input valid, out_words, output ready);
endinterface

// ----- rtl/b3h_compress.sv -----
// Seven-round compression engine, one quarter of a G function per cycle.
module b3h_compress (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  b3h_pkg::t_cmp_req  i_req,
    output logic               o_done,
    output b3h_pkg::t_blk      o_res
);
    import b3h_pkg::*;

    t_blk       r_v, n_v;
    t_blk       r_m, n_m;
    t_cv        r_cvin;
    logic [1:0] r_ph;
    logic [2:0] r_g;
    logic [2:0] r_rnd;
    logic       r_busy;
    logic       r_done;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    always_comb begin
        t_blk        vg, vr, mr;
        logic [31:0] s;
        vg = r_v;
        n_v = r_v;
        n_m = r_m;
        case (r_ph)
            2'd0: begin
                s = r_v[0] + r_v[4] + r_m[0];
                vg[0] = s;
                vg[12] = rotr(r_v[12] ^ s, 16);
            end
            2'd1: begin
                s = r_v[8] + r_v[12];
                vg[8] = s;
                vg[4] = rotr(r_v[4] ^ s, 12);
            end
            2'd2: begin
                s = r_v[0] + r_v[4] + r_m[1];
                vg[0] = s;
                vg[12] = rotr(r_v[12] ^ s, 8);
            end
            default: begin
                s = r_v[8] + r_v[12];
                vg[8] = s;
                vg[4] = rotr(r_v[4] ^ s, 7);
            end
        endcase
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                vr[r*4 + c] = vg[r*4 + ((c + 1) % 4)];
            end
        end
        for (int i = 0; i < 16; i++) begin
            mr[i] = r_m[(i + 2) % 16];
        end
        if (r_ph != 2'd3) begin
            n_v = vg;
        end else if (r_g == 3'd3) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    n_v[r*4 + c] = vr[r*4 + ((c + r) % 4)];
                end
            end
        end else if (r_g == 3'd7) begin
            for (int r = 0; r < 4; r++) begin
                for (int c = 0; c < 4; c++) begin
                    n_v[r*4 + c] = vr[r*4 + ((c + 4 - r) % 4)];
                end
            end
        end else begin
            n_v = vr;
        end
        if (r_ph == 2'd3) begin
            if (r_g == 3'd7) begin
                for (int i = 0; i < 16; i++) begin
                    n_m[i] = mr[PERM[i]];
                end
            end else begin
                n_m = mr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= i_req.cv[i];
            end
            for (int i = 0; i < 4; i++) begin
                r_v[8 + i] <= IV[i];
            end
            r_v[12] <= i_req.ctr[31:0];
            r_v[13] <= i_req.ctr[63:32];
            r_v[14] <= {25'd0, i_req.len};
            r_v[15] <= {28'd0, i_req.flags};
            r_cvin <= i_req.cv;
        end else if (r_busy) begin
            r_v <= n_v;
            r_m <= n_m;
        end else if (i_req.ld_en) begin
            for (int i = 0; i < 15; i++) begin
                r_m[i] <= r_m[i + 1];
            end
            r_m[15] <= i_req.ld_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ph <= 2'd0;
            r_g <= 3'd0;
            r_rnd <= 3'd0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_ph <= 2'd0;
            r_g <= 3'd0;
            r_rnd <= 3'd0;
        end else if (r_busy) begin
            r_ph <= r_ph + 2'd1;
            if (r_ph == 2'd3) begin
                r_g <= r_g + 3'd1;
                if (r_g == 3'd7) begin
                    r_rnd <= r_rnd + 3'd1;
                end
            end
            r_done <= (r_rnd == 3'd6) && (r_g == 3'd7) && (r_ph == 2'd3);
            if ((r_rnd == 3'd6) && (r_g == 3'd7) && (r_ph == 2'd3)) begin
                r_busy <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            o_res[i] = r_v[i] ^ r_v[i + 8];
            o_res[i + 8] = r_v[i + 8] ^ r_cvin[i];
        end
    end

    assign o_done = r_done;

    done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done raised while busy");

    start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |=> (r_busy && r_ph == 2'd0 && r_g == 3'd0 && r_rnd == 3'd0))
        else $error("start did not reset sequencer");

    no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_req.ld_en)
        else $error("message load during compression");

endmodule

// ----- rtl/blake3_stream_hasher_unit.sv -----
// Top level of the BLAKE3 stream hasher: sequencer, block and stack memories.
// Usage:
//   i_in carries one word per handshake: kind 0 with a message byte, or kind 1
//   to finish the message. o_out carries digest words (hash_word, word_index,
//   last). i_cfg sets the digest word count (1..64, 0 means 1, above 64 means 64);
//   write it only while the block is idle.
// Flow:
//   A byte is written straight into the 64-byte block buffer while it has room.
//   The byte after a full block is held while the block is loaded into the G engine,
//   compression is started and run (a quarter G per cycle), and the byte is written.
//   A chunk end adds a parent compression and a merge step per merge.
//   Finish runs one compression per stack level, then one root compression
//   per 16 digest words; each word is registered and then held until o_out takes it.
// Reset:
//   Sets chaining value to IV, clears counters and stack pointer; word count becomes 8.
//   The memories are not cleared: the block buffer is masked by its fill
//   count and only stack entries below the pointer are read.
// Stall:
//   A word on o_out holds until taken; no new input is taken meanwhile.
module blake3_stream_hasher_unit #(
    parameter int STACK_DEPTH = 54
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    b3h_in_if.sink  i_in,
    b3h_out_if.source o_out,
    b3h_cfg_if.sink i_cfg
);
    import b3h_pkg::*;

    localparam int SC_W = $clog2(STACK_DEPTH + 1);
    localparam int SA_W = $clog2(STACK_DEPTH);

    t_state r_state, n_state;
    t_job   r_job;
    t_src   r_src, r_rsrc;

    logic [6:0]      r_ow;
    t_cv             r_cv;
    logic [6:0]      r_fill;
    logic [3:0]      r_bd;
    logic [63:0]     r_ci;
    logic [SC_W-1:0] r_sc;
    logic [63:0]     r_total;
    t_cv             r_cur;
    logic [7:0]      r_pend;
    logic [5:0]      r_k;
    logic [4:0]      r_ld;
    logic            r_riv, r_civ;
    logic [6:0]      r_rlen, r_clen;
    logic [3:0]      r_rflags, r_cflags;
    logic [63:0]     r_cctr;
    t_cv             r_sdat;
    logic [3:0][7:0] r_mrd;
    logic            r_ov;
    logic [31:0]     r_oword;
    logic [5:0]      r_oidx;
    logic            r_olast;

    logic [3:0][7:0] r_msg_mem [16];
    logic [255:0]    r_stk_mem [STACK_DEPTH];

    t_cmp_req        cmp_req;
    logic            cmp_done;
    t_blk            cmp_res;

    logic            in_acc, out_acc;
    logic [3:0]      start_flag;
    logic [6:0]      ow_n;
    logic            last_word;
    logic            merge_go;
    logic [SC_W-1:0] sc_m1;
    logic [4:0]      ld_m1;
    logic [31:0]     ld_word;
    logic            wr_en;
    logic [5:0]      wr_pos;
    logic [7:0]      wr_byte;
    t_cv             res_cv;

    assign in_acc = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ov;
    assign o_out.hash_word = r_oword;
    assign o_out.word_index = r_oidx;
    assign o_out.last = r_olast;

    assign start_flag = (r_bd == 4'd0) ? FLAG_CHUNK_START : 4'd0;
    assign ow_n = (r_ow == 7'd0) ? 7'd1 : ((r_ow > MAX_WORDS) ? MAX_WORDS : r_ow);
    assign last_word = (({1'b0, r_k} + 7'd1) == ow_n);
    assign merge_go = !r_total[0] && (r_total != 64'd0) && (r_sc != '0);
    assign sc_m1 = r_sc - 1'b1;
    assign ld_m1 = r_ld - 5'd1;
    assign res_cv = cmp_res[7:0];

    always_comb begin
        logic [3:0] w;
        w = ld_m1[3:0];
        ld_word = '0;
        if (r_src == SRC_BUF) begin
            for (int j = 0; j < 4; j++) begin
                if ({1'b0, w, 2'(j)} < r_fill) begin
                    ld_word[j*8 +: 8] = r_mrd[j];
                end
            end
        end else begin
            ld_word = w[3] ? r_cur[w[2:0]] : r_sdat[w[2:0]];
        end
    end

    always_comb begin
        cmp_req.start = (r_state == S_GO);
        cmp_req.ld_en = (r_state == S_LOAD) && (r_ld != 5'd0);
        cmp_req.ld_word = ld_word;
        cmp_req.len = r_clen;
        cmp_req.ctr = r_cctr;
        cmp_req.flags = r_cflags;
        cmp_req.cv = r_civ ? IV : r_cv;
    end

    b3h_compress u_comp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cmp_req),
        .o_done  (cmp_done),
        .o_res   (cmp_res)
    );

    always_comb begin
        wr_en = 1'b0;
        wr_pos = r_fill[5:0];
        wr_byte = i_in.data_byte;
        if (r_state == S_IDLE && in_acc && i_in.kind == 1'b0 && r_fill != BLOCK_BYTES) begin
            wr_en = 1'b1;
        end else if (r_state == S_BYTE) begin
            wr_en = 1'b1;
            wr_pos = 6'd0;
            wr_byte = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_msg_mem[wr_pos[5:2]][wr_pos[1:0]] <= wr_byte;
        end
        r_mrd <= r_msg_mem[r_ld[3:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MERGE && !merge_go && r_sc < SC_W'(STACK_DEPTH)) begin
            r_stk_mem[r_sc[SA_W-1:0]] <= r_cur;
        end
        if (r_state == S_LOAD && r_ld == 5'd0) begin
            r_sdat <= r_stk_mem[sc_m1[SA_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in.kind == 1'b1) begin
                        n_state = (r_sc == '0) ? S_ROOT : S_LOAD;
                    end else if (r_fill == BLOCK_BYTES) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (r_ld == LOAD_WORDS) begin
                    n_state = S_GO;
                end
            end
            S_GO: n_state = S_COMP;
            S_COMP: begin
                if (cmp_done) begin
                    unique case (r_job)
                        J_BLOCK:            n_state = S_BYTE;
                        J_CHUNK, J_MERGE:   n_state = S_MERGE;
                        J_FCHUNK, J_FOLD:   n_state = S_FOLD;
                        default:            n_state = S_EMIT;
                    endcase
                end
            end
            S_MERGE: n_state = merge_go ? S_LOAD : S_BYTE;
            S_BYTE:  n_state = S_IDLE;
            S_FOLD:  n_state = (r_sc > SC_W'(1)) ? S_LOAD : S_ROOT;
            S_ROOT:  n_state = S_LOAD;
            S_EMIT:  n_state = S_WAIT;
            S_WAIT: begin
                if (out_acc) begin
                    if (r_olast) begin
                        n_state = S_IDLE;
                    end else if (r_k[3:0] == 4'd15) begin
                        n_state = S_ROOT;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_pend <= i_in.data_byte;
            r_k <= 6'd0;
            r_src <= SRC_BUF;
            r_civ <= 1'b0;
            r_clen <= r_fill;
            r_cctr <= r_ci;
            r_ld <= 5'd0;
            if (i_in.kind == 1'b1) begin
                r_job <= J_FCHUNK;
                r_cflags <= start_flag | FLAG_CHUNK_END;
                r_rsrc <= SRC_BUF;
                r_riv <= 1'b0;
                r_rlen <= r_fill;
                r_rflags <= start_flag | FLAG_CHUNK_END;
            end else if (r_bd == LAST_BLOCK) begin
                r_job <= J_CHUNK;
                r_cflags <= start_flag | FLAG_CHUNK_END;
            end else begin
                r_job <= J_BLOCK;
                r_cflags <= start_flag;
            end
        end
        if (r_state == S_LOAD) begin
            r_ld <= r_ld + 5'd1;
        end
        if (r_state == S_COMP && cmp_done) begin
            if (r_job == J_CHUNK) begin
                r_total <= r_ci + 64'd1;
            end else if (r_job == J_MERGE) begin
                r_total <= {1'b0, r_total[63:1]};
            end
            if (r_job != J_BLOCK && r_job != J_ROOT) begin
                r_cur <= res_cv;
            end
        end
        if ((r_state == S_MERGE && merge_go) || (r_state == S_FOLD && r_sc > SC_W'(1))) begin
            r_job <= (r_state == S_MERGE) ? J_MERGE : J_FOLD;
            r_src <= SRC_PAIR;
            r_civ <= 1'b1;
            r_clen <= BLOCK_BYTES;
            r_cctr <= 64'd0;
            r_cflags <= FLAG_PARENT;
            r_ld <= 5'd0;
        end
        if (r_state == S_FOLD && r_sc <= SC_W'(1)) begin
            r_rsrc <= SRC_PAIR;
            r_riv <= 1'b1;
            r_rlen <= BLOCK_BYTES;
            r_rflags <= FLAG_PARENT;
        end
        if (r_state == S_ROOT) begin
            r_job <= J_ROOT;
            r_src <= r_rsrc;
            r_civ <= r_riv;
            r_clen <= r_rlen;
            r_cctr <= {62'd0, r_k[5:4]};
            r_cflags <= r_rflags | FLAG_ROOT;
            r_ld <= 5'd0;
        end
        if (r_state == S_EMIT) begin
            r_oword <= cmp_res[r_k[3:0]];
            r_oidx <= r_k;
            r_olast <= last_word;
        end
        if (r_state == S_WAIT && out_acc) begin
            r_k <= r_k + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ow <= OW_RESET;
            r_cv <= IV;
            r_fill <= 7'd0;
            r_bd <= 4'd0;
            r_ci <= 64'd0;
            r_sc <= '0;
            r_ov <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_ow <= i_cfg.out_words;
            end
            if (r_state == S_IDLE && in_acc && i_in.kind == 1'b0
                    && r_fill != BLOCK_BYTES) begin
                r_fill <= r_fill + 7'd1;
            end
            if (r_state == S_COMP && cmp_done) begin
                unique case (r_job)
                    J_BLOCK: begin
                        r_cv <= res_cv;
                        r_bd <= r_bd + 4'd1;
                        r_fill <= 7'd0;
                    end
                    J_CHUNK: begin
                        r_cv <= IV;
                        r_bd <= 4'd0;
                        r_fill <= 7'd0;
                        r_ci <= r_ci + 64'd1;
                    end
                    J_MERGE, J_FOLD: r_sc <= r_sc - 1'b1;
                    default: ;
                endcase
            end
            if (r_state == S_MERGE && !merge_go && r_sc < SC_W'(STACK_DEPTH)) begin
                r_sc <= r_sc + 1'b1;
            end
            if (r_state == S_BYTE) begin
                r_fill <= 7'd1;
            end
            if (r_state == S_EMIT) begin
                r_ov <= 1'b1;
            end
            if (r_state == S_WAIT && out_acc) begin
                r_ov <= 1'b0;
                if (r_olast) begin
                    r_cv <= IV;
                    r_fill <= 7'd0;
                    r_bd <= 4'd0;
                    r_ci <= 64'd0;
                    r_sc <= '0;
                end
            end
        end
    end

    in_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_state == S_IDLE))
        else $error("input word taken outside idle");

    out_only_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (r_state == S_WAIT))
        else $error("output valid outside wait");

    fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= BLOCK_BYTES)
        else $error("block fill overflow");

    stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sc <= SC_W'(STACK_DEPTH))
        else $error("stack pointer overflow");

endmodule
